@@ sv/tdpe_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpe_pkg
// Shared types, constants and decode helpers for the thumb data-processing
// execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpe_pkg;

	// register file geometry
	localparam int REG_W     = 32;
	localparam int NUM_REGS  = 15;
	localparam int REG_IDX_W = 4;

	localparam logic [REG_IDX_W-1:0] PC_INDEX = 4'd15;

	// shift by immediate opcodes
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;

	// 8-bit immediate opcodes
	localparam logic [1:0] IMM_MOV = 2'd0;
	localparam logic [1:0] IMM_CMP = 2'd1;
	localparam logic [1:0] IMM_ADD = 2'd2;
	localparam logic [1:0] IMM_SUB = 2'd3;

	// alu opcodes that are handled
	localparam logic [3:0] ALU_CMP = 4'hA;
	localparam logic [3:0] ALU_BIC = 4'hE;

	// hi-register opcodes
	localparam logic [1:0] HI_ADD = 2'd0;
	localparam logic [1:0] HI_CMP = 2'd1;
	localparam logic [1:0] HI_MOV = 2'd2;
	localparam logic [1:0] HI_BX  = 2'd3;

	// instruction formats
	typedef enum logic [2:0] {
		FMT_SHIFT,
		FMT_ADDSUB,
		FMT_IMM8,
		FMT_ALU,
		FMT_HIREG,
		FMT_NONE
	} fmt_t;

	// one result transaction
	typedef struct packed {
		logic                 reg_written;
		logic [REG_IDX_W-1:0] dest_index;
		logic [REG_W-1:0]     dest_value;
		logic                 flag_n;
		logic                 flag_z;
		logic                 flag_c;
		logic                 flag_v;
		logic                 branch_taken;
		logic [REG_W-1:0]     branch_target;
		logic                 thumb_state;
		logic                 unsupported;
	} res_t;

	// format decode of a thumb instruction word
	function automatic fmt_t get_fmt(input logic [15:0] ins);
		fmt_t f;
		if (ins[15:13] == 3'b000 && ins[12:11] != 2'b11)
			f = FMT_SHIFT;
		else if (ins[15:11] == 5'b00011)
			f = FMT_ADDSUB;
		else if (ins[15:13] == 3'b001)
			f = FMT_IMM8;
		else if (ins[15:10] == 6'b010000)
			f = FMT_ALU;
		else if (ins[15:10] == 6'b010001)
			f = FMT_HIREG;
		else
			f = FMT_NONE;
		return f;
	endfunction

endpackage

`default_nettype wire

@@ sv/tdpe_ram.sv @@
// ----------------------------------------------------------------------------
// tdpe_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/thumb_data_processing_execute_top.sv @@
// Pipeline: an accepted instruction passes through the input register, then the
// result register; a high out_stall can hold it in the input register.
// Throughput: one instruction per cycle while out_stall is low; the register file
// and flags are read and updated on execute, with write forwarding into the reads.
// Reset: arst_n clears the flags, the register file valid bits (every register
// reads as zero until written) and both valid registers.
// ----------------------------------------------------------------------------
// thumb_data_processing_execute_top
// Executes one Thumb data-processing instruction per transaction: shifts,
// add/subtract, 8-bit immediate ops, ALU CMP/BIC and hi-register ops with BX.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_data_processing_execute_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] instruction,
	input  wire logic [31:0] pc_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             reg_written,
	output logic [3:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             flag_n,
	output logic             flag_z,
	output logic             flag_c,
	output logic             flag_v,
	output logic             branch_taken,
	output logic [31:0]      branch_target,
	output logic             thumb_state,
	output logic             unsupported
);

	import tdpe_pkg::*;

	// handshake and pipeline control
	logic                 in_accept;
	logic                 exec_fire;
	logic                 s1_valid_q;
	logic                 out_valid_q;

	// input stage
	logic [15:0]          instr_s1;
	logic [REG_W-1:0]     pc_s1;
	logic [REG_IDX_W-1:0] raddr_a;
	logic [REG_IDX_W-1:0] raddr_b;
	fmt_t                 in_fmt;
	logic                 vld_a_s1;
	logic                 vld_b_s1;
	logic                 fwd_a_s1;
	logic                 fwd_b_s1;
	logic [REG_W-1:0]     fwd_data_s1;
	logic [REG_W-1:0]     ram_a;
	logic [REG_W-1:0]     ram_b;
	logic [NUM_REGS-1:0]  vld_q;

	// execute
	fmt_t                 fmt;
	logic [REG_W-1:0]     op_a;
	logic [REG_W-1:0]     op_b;
	logic [REG_IDX_W-1:0] hi_d;
	logic [REG_IDX_W-1:0] hi_s;
	logic [REG_W-1:0]     hi_vd;
	logic [REG_W-1:0]     hi_vs;
	logic [REG_W-1:0]     add_a;
	logic [REG_W-1:0]     add_b;
	logic                 add_sub;
	logic [REG_W-1:0]     add_b_eff;
	logic [REG_W:0]       sum;
	logic [REG_W-1:0]     sum_r;
	logic                 sum_c;
	logic                 sum_v;
	logic [4:0]           sh_n;
	logic [3:0]           flags_q;
	logic [3:0]           flags_d;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_idx;
	res_t                 res_d;
	res_t                 res_q;

	assign exec_fire = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !exec_fire;
	assign in_accept = in_valid && !in_stall;

	// read address selection on the incoming instruction
	always_comb begin
		in_fmt  = get_fmt(instruction);
		raddr_a = {1'b0, instruction[5:3]};
		raddr_b = {1'b0, instruction[8:6]};
		case (in_fmt)
			FMT_IMM8:  raddr_a = {1'b0, instruction[10:8]};
			FMT_ALU: begin
				raddr_a = {1'b0, instruction[2:0]};
				raddr_b = {1'b0, instruction[5:3]};
			end
			FMT_HIREG: begin
				raddr_a = {instruction[7], instruction[2:0]};
				raddr_b = {instruction[6], instruction[5:3]};
			end
			default: ;
		endcase
	end

	// register file, one copy per read port
	tdpe_ram #(.WIDTH(REG_W), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (res_d.dest_value),
		.re    (in_accept),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	tdpe_ram #(.WIDTH(REG_W), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (res_d.dest_value),
		.re    (in_accept),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	// valid bits of the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// input register with forwarding of the write in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (exec_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			instr_s1    <= instruction;
			pc_s1       <= pc_value;
			vld_a_s1    <= (raddr_a != PC_INDEX) ? vld_q[raddr_a] : 1'b0;
			vld_b_s1    <= (raddr_b != PC_INDEX) ? vld_q[raddr_b] : 1'b0;
			fwd_a_s1    <= wr_en && (wr_idx == raddr_a);
			fwd_b_s1    <= wr_en && (wr_idx == raddr_b);
			fwd_data_s1 <= res_d.dest_value;
		end
	end

	// operands after forwarding, r15 reads the pc
	always_comb begin
		fmt   = get_fmt(instr_s1);
		op_a  = fwd_a_s1 ? fwd_data_s1 : (vld_a_s1 ? ram_a : '0);
		op_b  = fwd_b_s1 ? fwd_data_s1 : (vld_b_s1 ? ram_b : '0);
		hi_d  = {instr_s1[7], instr_s1[2:0]};
		hi_s  = {instr_s1[6], instr_s1[5:3]};
		hi_vd = (hi_d == PC_INDEX) ? pc_s1 : op_a;
		hi_vs = (hi_s == PC_INDEX) ? pc_s1 : op_b;
		sh_n  = instr_s1[10:6];
	end

	// shared adder operand selection
	always_comb begin
		add_a   = op_a;
		add_b   = op_b;
		add_sub = 1'b0;
		case (fmt)
			FMT_ADDSUB: begin
				add_b   = instr_s1[10] ? {29'd0, instr_s1[8:6]} : op_b;
				add_sub = instr_s1[9];
			end
			FMT_IMM8: begin
				add_b   = {24'd0, instr_s1[7:0]};
				add_sub = (instr_s1[12:11] != IMM_ADD);
			end
			FMT_ALU:   add_sub = 1'b1;
			FMT_HIREG: begin
				add_a   = hi_vd;
				add_b   = hi_vs;
				add_sub = (instr_s1[9:8] == HI_CMP);
			end
			default: ;
		endcase
	end

	assign add_b_eff = add_sub ? ~add_b : add_b;
	assign sum       = {1'b0, add_a} + {1'b0, add_b_eff} + {{REG_W{1'b0}}, add_sub};
	assign sum_r     = sum[REG_W-1:0];
	assign sum_c     = sum[REG_W];
	assign sum_v     = ~(add_a[REG_W-1] ^ add_b_eff[REG_W-1]) & (add_a[REG_W-1] ^ sum_r[REG_W-1]);

	// result and flag computation
	always_comb begin
		res_d             = '0;
		res_d.thumb_state = 1'b1;
		flags_d           = flags_q;
		wr_en             = 1'b0;
		wr_idx            = '0;
		case (fmt)
			FMT_SHIFT: begin
				res_d.reg_written = 1'b1;
				res_d.dest_index  = {1'b0, instr_s1[2:0]};
				if (instr_s1[12:11] == SH_LSL) begin
					if (sh_n == 5'd0) begin
						res_d.dest_value = op_a;
					end else begin
						flags_d[1]       = op_a[5'd0 - sh_n];
						res_d.dest_value = op_a << sh_n;
					end
				end else if (sh_n == 5'd0) begin
					flags_d[1]       = op_a[31];
					res_d.dest_value = (instr_s1[12:11] == SH_ASR && op_a[31]) ? '1 : '0;
				end else begin
					flags_d[1] = op_a[sh_n - 5'd1];
					if (instr_s1[12:11] == SH_ASR)
						res_d.dest_value = $unsigned($signed(op_a) >>> sh_n);
					else
						res_d.dest_value = op_a >> sh_n;
				end
				flags_d[3] = res_d.dest_value[31];
				flags_d[2] = (res_d.dest_value == '0);
			end
			FMT_ADDSUB: begin
				res_d.reg_written = 1'b1;
				res_d.dest_index  = {1'b0, instr_s1[2:0]};
				res_d.dest_value  = sum_r;
				flags_d           = {sum_r[31], sum_r == '0, sum_c, sum_v};
			end
			FMT_IMM8: begin
				if (instr_s1[12:11] == IMM_MOV) begin
					res_d.dest_value = {24'd0, instr_s1[7:0]};
					flags_d[3]       = 1'b0;
					flags_d[2]       = (instr_s1[7:0] == 8'd0);
				end else begin
					res_d.dest_value = sum_r;
					flags_d          = {sum_r[31], sum_r == '0, sum_c, sum_v};
				end
				if (instr_s1[12:11] != IMM_CMP) begin
					res_d.reg_written = 1'b1;
					res_d.dest_index  = {1'b0, instr_s1[10:8]};
				end else begin
					res_d.dest_value = '0;
				end
			end
			FMT_ALU: begin
				if (instr_s1[9:6] == ALU_CMP) begin
					flags_d = {sum_r[31], sum_r == '0, sum_c, sum_v};
				end else if (instr_s1[9:6] == ALU_BIC) begin
					res_d.reg_written = 1'b1;
					res_d.dest_index  = {1'b0, instr_s1[2:0]};
					res_d.dest_value  = op_a & ~op_b;
					flags_d[3]        = res_d.dest_value[31];
					flags_d[2]        = (res_d.dest_value == '0);
				end else begin
					res_d.unsupported = 1'b1;
				end
			end
			FMT_HIREG: begin
				case (instr_s1[9:8])
					HI_CMP: flags_d = {sum_r[31], sum_r == '0, sum_c, sum_v};
					HI_BX: begin
						res_d.branch_taken  = 1'b1;
						res_d.dest_index    = PC_INDEX;
						res_d.branch_target = {hi_vs[31:1], 1'b0};
						res_d.dest_value    = {hi_vs[31:1], 1'b0};
						res_d.thumb_state   = hi_vs[0];
					end
					default: begin
						res_d.dest_index = hi_d;
						res_d.dest_value = (instr_s1[9:8] == HI_ADD) ? sum_r : hi_vs;
						if (hi_d == PC_INDEX) begin
							res_d.branch_taken  = 1'b1;
							res_d.branch_target = res_d.dest_value;
						end else begin
							res_d.reg_written = 1'b1;
						end
					end
				endcase
			end
			default: res_d.unsupported = 1'b1;
		endcase
		res_d.flag_n = flags_d[3];
		res_d.flag_z = flags_d[2];
		res_d.flag_c = flags_d[1];
		res_d.flag_v = flags_d[0];
		wr_en        = exec_fire && res_d.reg_written;
		wr_idx       = res_d.dest_index;
	end

	// condition flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (exec_fire) begin
			flags_q <= flags_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire)
			res_q <= res_d;
	end

	// output ports
	assign out_valid     = out_valid_q;
	assign reg_written   = res_q.reg_written;
	assign dest_index    = res_q.dest_index;
	assign dest_value    = res_q.dest_value;
	assign flag_n        = res_q.flag_n;
	assign flag_z        = res_q.flag_z;
	assign flag_c        = res_q.flag_c;
	assign flag_v        = res_q.flag_v;
	assign branch_taken  = res_q.branch_taken;
	assign branch_target = res_q.branch_target;
	assign thumb_state   = res_q.thumb_state;
	assign unsupported   = res_q.unsupported;

	// checks
	a_unsup_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.unsupported |-> !res_q.reg_written && !res_q.branch_taken)
		else $error("unsupported transaction reports a write or branch");

	a_write_xor_branch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.reg_written && res_q.branch_taken))
		else $error("register write and branch in one transaction");

	a_write_not_pc: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_idx != PC_INDEX)
		else $error("register file write to r15");

	a_arm_only_on_bx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.thumb_state |-> res_q.branch_taken && res_q.dest_index == PC_INDEX)
		else $error("state change without branch");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> $stable(flags_q))
		else $error("flags changed without execution");

endmodule

`default_nettype wire

@@ tb/sv/thumb_data_processing_execute_top_test.sv @@
// ----------------------------------------------------------------------------
// thumb_data_processing_execute_top_test
// Self-checking bench for the thumb execute block. It runs a directed opening
// over the shift, add/subtract, immediate, ALU and hi-register groups. Then it
// runs a long random run of mostly well-formed instructions with random content.
// A scoreboard keeps its own register file and flags and predicts every result.
// Both sides idle at random, and the receiver holds off for long stretches.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_data_processing_execute_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tdpe_pkg::*;

	// format prefixes of the instruction word
	localparam logic [2:0] PFX_SHIFT  = 3'b000;
	localparam logic [4:0] PFX_ADDSUB = 5'b00011;
	localparam logic [2:0] PFX_IMM8   = 3'b001;
	localparam logic [5:0] PFX_ALU    = 6'b010000;
	localparam logic [5:0] PFX_HIREG  = 6'b010001;

	// alu op that the block does not handle
	localparam logic [3:0] ALU_AND = 4'h0;

	localparam int NUM_RANDOM  = 1825;
	localparam int QUIET_TAIL  = 150;
	localparam int HOLD_CYCLES = 60;

	// one retired instruction and the word that caused it
	typedef struct {
		res_t        result;
		logic [15:0] ins;
	} retire_t;

	// ------------------------------------------------------------------------
	// scoreboard: architectural state and expected retire transactions
	// ------------------------------------------------------------------------
	class retire_checker;
		logic [31:0] gpr [15];
		logic        fl_n, fl_z, fl_c, fl_v;
		retire_t     pending_retires[$];
		int unsigned mismatches;

		function new();
			foreach (gpr[i])
				gpr[i] = '0;
			{fl_n, fl_z, fl_c, fl_v} = 4'b0000;
			mismatches = 0;
		endfunction

		function void set_nz(logic [31:0] r);
			fl_n = r[31];
			fl_z = (r == '0);
		endfunction

		// a + b + cin with all four flags updated
		function logic [31:0] add_with_flags(logic [31:0] a, logic [31:0] b, logic cin);
			logic [32:0] sum;
			logic [31:0] ovf;
			sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
			ovf = ~(a ^ b) & (a ^ sum[31:0]);
			set_nz(sum[31:0]);
			fl_c = sum[32];
			fl_v = ovf[31];
			return sum[31:0];
		endfunction

		// execute one accepted instruction and queue its expected retire
		function void note_issue(logic [15:0] ins, logic [31:0] pc);
			fmt_t        fmt;
			res_t        exp;
			retire_t     entry;
			logic [1:0]  op2;
			logic [3:0]  op4, s_idx, d_idx;
			logic [4:0]  amt;
			logic [31:0] v, r, a, b, vs, vd;
			logic        c;

			if (ins[15:13] == PFX_SHIFT && ins[12:11] != 2'b11)
				fmt = FMT_SHIFT;
			else if (ins[15:11] == PFX_ADDSUB)
				fmt = FMT_ADDSUB;
			else if (ins[15:13] == PFX_IMM8)
				fmt = FMT_IMM8;
			else if (ins[15:10] == PFX_ALU)
				fmt = FMT_ALU;
			else if (ins[15:10] == PFX_HIREG)
				fmt = FMT_HIREG;
			else
				fmt = FMT_NONE;

			exp = '0;
			exp.thumb_state = 1'b1;

			case (fmt)
				FMT_SHIFT: begin
					op2 = ins[12:11];
					amt = ins[10:6];
					v   = gpr[{1'b0, ins[5:3]}];
					c   = fl_c;
					if (op2 == SH_LSL) begin
						// lsl #0 moves the value and keeps carry
						if (amt == 5'd0) begin
							r = v;
						end else begin
							c = v[5'd0 - amt];
							r = v << amt;
						end
					end else if (amt == 5'd0) begin
						// lsr/asr #0 shift by 32
						c = v[31];
						r = (op2 == SH_ASR && c) ? 32'hFFFF_FFFF : 32'd0;
					end else begin
						c = v[amt - 5'd1];
						r = v >> amt;
						if (op2 == SH_ASR && v[31])
							r = r | ~(32'hFFFF_FFFF >> amt);
					end
					set_nz(r);
					fl_c = c;
					gpr[{1'b0, ins[2:0]}] = r;
					exp.reg_written = 1'b1;
					exp.dest_index  = {1'b0, ins[2:0]};
					exp.dest_value  = r;
				end
				FMT_ADDSUB: begin
					a = gpr[{1'b0, ins[5:3]}];
					b = ins[10] ? {29'd0, ins[8:6]} : gpr[{1'b0, ins[8:6]}];
					r = ins[9] ? add_with_flags(a, ~b, 1'b1) : add_with_flags(a, b, 1'b0);
					gpr[{1'b0, ins[2:0]}] = r;
					exp.reg_written = 1'b1;
					exp.dest_index  = {1'b0, ins[2:0]};
					exp.dest_value  = r;
				end
				FMT_IMM8: begin
					op2 = ins[12:11];
					a   = gpr[{1'b0, ins[10:8]}];
					b   = {24'd0, ins[7:0]};
					if (op2 == IMM_MOV) begin
						r = b;
						set_nz(r);
					end else if (op2 == IMM_ADD) begin
						r = add_with_flags(a, b, 1'b0);
					end else begin
						r = add_with_flags(a, ~b, 1'b1);
					end
					// cmp only sets flags
					if (op2 != IMM_CMP) begin
						gpr[{1'b0, ins[10:8]}] = r;
						exp.reg_written = 1'b1;
						exp.dest_index  = {1'b0, ins[10:8]};
						exp.dest_value  = r;
					end
				end
				FMT_ALU: begin
					op4 = ins[9:6];
					a   = gpr[{1'b0, ins[2:0]}];
					b   = gpr[{1'b0, ins[5:3]}];
					if (op4 == ALU_CMP) begin
						void'(add_with_flags(a, ~b, 1'b1));
					end else if (op4 == ALU_BIC) begin
						r = a & ~b;
						set_nz(r);
						gpr[{1'b0, ins[2:0]}] = r;
						exp.reg_written = 1'b1;
						exp.dest_index  = {1'b0, ins[2:0]};
						exp.dest_value  = r;
					end else begin
						exp.unsupported = 1'b1;
					end
				end
				FMT_HIREG: begin
					op2   = ins[9:8];
					s_idx = {ins[6], ins[5:3]};
					d_idx = {ins[7], ins[2:0]};
					vs    = (s_idx == PC_INDEX) ? pc : gpr[s_idx];
					vd    = (d_idx == PC_INDEX) ? pc : gpr[d_idx];
					if (op2 == HI_CMP) begin
						// rd minus rs
						void'(add_with_flags(vd, ~vs, 1'b1));
					end else if (op2 == HI_BX) begin
						exp.branch_taken  = 1'b1;
						exp.dest_index    = PC_INDEX;
						exp.branch_target = {vs[31:1], 1'b0};
						exp.dest_value    = {vs[31:1], 1'b0};
						exp.thumb_state   = vs[0];
					end else begin
						r = (op2 == HI_ADD) ? vd + vs : vs;
						exp.dest_index = d_idx;
						exp.dest_value = r;
						// a write to r15 is a branch, not a register write
						if (d_idx == PC_INDEX) begin
							exp.branch_taken  = 1'b1;
							exp.branch_target = r;
						end else begin
							gpr[d_idx] = r;
							exp.reg_written = 1'b1;
						end
					end
				end
				default: begin
					exp.unsupported = 1'b1;
				end
			endcase

			exp.flag_n = fl_n;
			exp.flag_z = fl_z;
			exp.flag_c = fl_c;
			exp.flag_v = fl_v;
			entry.result = exp;
			entry.ins    = ins;
			pending_retires.push_back(entry);
		endfunction

		function void compare_field(string name, logic [15:0] ins,
				logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: ins %h %s expected %h actual %h",
					$time, ins, name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		// compare a retire transaction with the oldest expectation
		function void check_retire(res_t got);
			retire_t e;
			if (pending_retires.size() == 0) begin
				$display("%0t: unexpected result, expected none actual dest_value %h",
					$time, got.dest_value);
				mismatches++;
				return;
			end
			e = pending_retires.pop_front();
			compare_field("reg_written", e.ins, 32'(e.result.reg_written),
				32'(got.reg_written));
			compare_field("dest_index", e.ins, 32'(e.result.dest_index),
				32'(got.dest_index));
			compare_field("dest_value", e.ins, e.result.dest_value, got.dest_value);
			compare_field("flag_n", e.ins, 32'(e.result.flag_n), 32'(got.flag_n));
			compare_field("flag_z", e.ins, 32'(e.result.flag_z), 32'(got.flag_z));
			compare_field("flag_c", e.ins, 32'(e.result.flag_c), 32'(got.flag_c));
			compare_field("flag_v", e.ins, 32'(e.result.flag_v), 32'(got.flag_v));
			compare_field("branch_taken", e.ins, 32'(e.result.branch_taken),
				32'(got.branch_taken));
			compare_field("branch_target", e.ins, e.result.branch_target,
				got.branch_target);
			compare_field("thumb_state", e.ins, 32'(e.result.thumb_state),
				32'(got.thumb_state));
			compare_field("unsupported", e.ins, 32'(e.result.unsupported),
				32'(got.unsupported));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals and block under test
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] instruction = '0;
	logic [31:0] pc_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reg_written;
	logic [3:0]  dest_index;
	logic [31:0] dest_value;
	logic        flag_n, flag_z, flag_c, flag_v;
	logic        branch_taken;
	logic [31:0] branch_target;
	logic        thumb_state;
	logic        unsupported;

	bit idle_enable  = 1'b1;
	bit hold_request = 1'b0;

	retire_checker book = new();

	thumb_data_processing_execute_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.instruction   (instruction),
		.pc_value      (pc_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reg_written   (reg_written),
		.dest_index    (dest_index),
		.dest_value    (dest_value),
		.flag_n        (flag_n),
		.flag_z        (flag_z),
		.flag_c        (flag_c),
		.flag_v        (flag_v),
		.branch_taken  (branch_taken),
		.branch_target (branch_target),
		.thumb_state   (thumb_state),
		.unsupported   (unsupported)
	);

	// clock
	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// instruction encoders
	// ------------------------------------------------------------------------
	function automatic logic [15:0] enc_shift(logic [1:0] op, logic [4:0] amt,
			logic [2:0] rs, logic [2:0] rd);
		return {PFX_SHIFT, op, amt, rs, rd};
	endfunction

	function automatic logic [15:0] enc_addsub(logic imm, logic sub, logic [2:0] f,
			logic [2:0] rs, logic [2:0] rd);
		return {PFX_ADDSUB, imm, sub, f, rs, rd};
	endfunction

	function automatic logic [15:0] enc_imm8(logic [1:0] op, logic [2:0] rd,
			logic [7:0] imm);
		return {PFX_IMM8, op, rd, imm};
	endfunction

	function automatic logic [15:0] enc_alu(logic [3:0] op, logic [2:0] rs,
			logic [2:0] rd);
		return {PFX_ALU, op, rs, rd};
	endfunction

	function automatic logic [15:0] enc_hireg(logic [1:0] op, logic [3:0] rd,
			logic [3:0] rs);
		return {PFX_HIREG, op, rd[3], rs[3], rs[2:0], rd[2:0]};
	endfunction

	// ------------------------------------------------------------------------
	// sender: one instruction transaction, with an optional idle burst first
	// ------------------------------------------------------------------------
	task automatic send_instruction(logic [15:0] ins, logic [31:0] pc);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		instruction <= ins;
		pc_value    <= pc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.note_issue(ins, pc);
	endtask

	// ------------------------------------------------------------------------
	// receiver: check results, random stall bursts and long hold-offs
	// ------------------------------------------------------------------------
	initial begin
		int   stall_left;
		int   hold_left;
		res_t got;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.reg_written   = reg_written;
				got.dest_index    = dest_index;
				got.dest_value    = dest_value;
				got.flag_n        = flag_n;
				got.flag_z        = flag_z;
				got.flag_c        = flag_c;
				got.flag_v        = flag_v;
				got.branch_taken  = branch_taken;
				got.branch_target = branch_target;
				got.thumb_state   = thumb_state;
				got.unsupported   = unsupported;
				book.check_retire(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				stall_left = int'($urandom_range(1, 7)) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned pick;
		logic [15:0] ins;
		logic [31:0] pc;
		logic [4:0]  amt;
		logic [3:0]  alu_op;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every group and the corner cases
		send_instruction(enc_imm8(IMM_MOV, 3'd0, 8'hFF), $urandom);
		send_instruction(enc_imm8(IMM_MOV, 3'd1, 8'h00), $urandom);
		// load r8 with all ones through the pc read
		send_instruction(enc_hireg(HI_MOV, 4'd8, PC_INDEX), 32'hFFFF_FFFF);
		send_instruction(enc_hireg(HI_MOV, 4'd2, 4'd8), $urandom);
		// lsl #0 keeps carry, lsl #31
		send_instruction(enc_shift(SH_LSL, 5'd0, 3'd2, 3'd3), $urandom);
		send_instruction(enc_shift(SH_LSL, 5'd31, 3'd2, 3'd3), $urandom);
		// lsr #0 and asr #0 shift by 32
		send_instruction(enc_shift(SH_LSR, 5'd0, 3'd2, 3'd4), $urandom);
		send_instruction(enc_shift(SH_ASR, 5'd0, 3'd2, 3'd5), $urandom);
		send_instruction(enc_shift(SH_ASR, 5'd31, 3'd3, 3'd5), $urandom);
		send_instruction(enc_shift(SH_LSR, 5'd1, 3'd3, 3'd6), $urandom);
		// signed overflow on register add, immediate subtract
		send_instruction(enc_addsub(1'b0, 1'b0, 3'd6, 3'd6, 3'd7), $urandom);
		send_instruction(enc_addsub(1'b1, 1'b1, 3'd7, 3'd7, 3'd7), $urandom);
		send_instruction(enc_imm8(IMM_ADD, 3'd0, 8'hFF), $urandom);
		send_instruction(enc_imm8(IMM_SUB, 3'd1, 8'hFF), $urandom);
		send_instruction(enc_imm8(IMM_CMP, 3'd0, 8'h01), $urandom);
		// alu cmp, bic keeping carry and overflow, an unhandled alu op
		send_instruction(enc_alu(ALU_CMP, 3'd1, 3'd2), $urandom);
		send_instruction(enc_alu(ALU_BIC, 3'd6, 3'd2), $urandom);
		send_instruction(enc_alu(ALU_AND, 3'd2, 3'd1), $urandom);
		// hi-register cmp is rd minus rs, add sets no flags, add to pc
		send_instruction(enc_hireg(HI_CMP, 4'd8, 4'd9), $urandom);
		send_instruction(enc_hireg(HI_ADD, 4'd9, 4'd8), $urandom);
		send_instruction(enc_hireg(HI_ADD, PC_INDEX, 4'd0), 32'h0000_0000);
		// bx staying in thumb, bx pc with h1 set going to arm
		send_instruction(enc_hireg(HI_BX, 4'd0, 4'd8), $urandom);
		send_instruction(enc_hireg(HI_BX, 4'd8, PC_INDEX), 32'h0000_1000);
		// hi-register op with both operands low
		send_instruction(enc_hireg(HI_MOV, 4'd1, 4'd2), $urandom);
		// unhandled format
		send_instruction(16'hFFFF, $urandom);

		// random: mostly handled instructions with random content
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == 300 || i == 1100)
				hold_request = 1'b1;
			if (i == NUM_RANDOM - QUIET_TAIL)
				idle_enable = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				amt = 5'($urandom_range(0, 31));
				if ($urandom_range(0, 3) == 0)
					amt = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'd31;
				ins = enc_shift(2'($urandom_range(SH_LSL, SH_ASR)), amt,
					3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			end else if (pick < 28) begin
				ins = enc_addsub(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)));
			end else if (pick < 48) begin
				ins = enc_imm8(2'($urandom_range(IMM_MOV, IMM_SUB)),
					3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end else if (pick < 60) begin
				alu_op = 4'($urandom_range(0, 15));
				if ($urandom_range(0, 1) == 0)
					alu_op = ($urandom_range(0, 1) == 0) ? ALU_CMP : ALU_BIC;
				ins = enc_alu(alu_op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			end else if (pick < 85) begin
				ins = enc_hireg(2'($urandom_range(HI_ADD, HI_BX)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			end else begin
				ins = 16'($urandom_range(0, 65535));
			end
			pc = $urandom;
			if ($urandom_range(0, 15) == 0)
				pc = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
			send_instruction(ins, pc);
		end
		in_valid <= 1'b0;

		// drain and allow for stray results
		while (book.pending_retires.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (book.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
